FILE: design/dpcpc_pkg.sv
// shared types, constants and helpers of the dual pid cart and pendulum controller
`default_nettype none
package dpcpc_pkg;

	localparam int DataW = 32;
	localparam int OpW = DataW + 1;
	localparam int ProdW = 2 * OpW;
	localparam int SumW = 53;
	localparam int CfgIdxW = 3;
	localparam int StepCntW = 4;
	localparam int NumOps = 8;

	localparam logic [CfgIdxW-1:0] REG_CART_KP = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CART_KI = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CART_KD = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PEND_KP = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PEND_KI = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PEND_KD = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_TRAVEL = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_PERIOD = 3'd7;

	localparam logic [2:0] OP_CART_TRAP = 3'd0;
	localparam logic [2:0] OP_PEND_TRAP = 3'd1;
	localparam logic [2:0] OP_CART_KP = 3'd2;
	localparam logic [2:0] OP_CART_KD = 3'd3;
	localparam logic [2:0] OP_PEND_KP = 3'd4;
	localparam logic [2:0] OP_PEND_KD = 3'd5;
	localparam logic [2:0] OP_CART_KI = 3'd6;
	localparam logic [2:0] OP_PEND_KI = 3'd7;

	localparam logic signed [DataW-1:0] MaxS32 = 32'sh7FFF_FFFF;
	localparam logic signed [DataW-1:0] MinS32 = 32'sh8000_0000;

	localparam logic signed [DataW-1:0] RstCartKp = 32'sd327680;
	localparam logic signed [DataW-1:0] RstCartKi = 32'sd0;
	localparam logic signed [DataW-1:0] RstCartKd = -32'sd32768;
	localparam logic signed [DataW-1:0] RstPendKp = -32'sd9830400;
	localparam logic signed [DataW-1:0] RstPendKi = -32'sd6553600;
	localparam logic signed [DataW-1:0] RstPendKd = -32'sd655360;
	localparam logic signed [DataW-1:0] RstTravel = 32'sd131072;
	localparam logic [DataW-1:0] RstPeriod = 32'd1310720;

	typedef struct packed {
		logic [DataW-1:0] sim_time;
		logic [DataW-1:0] step_len;
		logic signed [DataW-1:0] cart_position;
		logic signed [DataW-1:0] cart_velocity;
		logic signed [DataW-1:0] pendulum_angle;
		logic signed [DataW-1:0] pendulum_rate;
	} in_item_t;

	typedef struct packed {
		logic signed [DataW-1:0] drive_force;
		logic target_flipped;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLIP,
		ST_ERR,
		ST_MUL,
		ST_DONE
	} state_t;

	function automatic logic signed [DataW-1:0] sat_s32(input logic signed [SumW-1:0] v);
		logic signed [DataW-1:0] r;
		if (v > SumW'(MaxS32)) begin
			r = MaxS32;
		end else if (v < SumW'(MinS32)) begin
			r = MinS32;
		end else begin
			r = v[DataW-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DataW-1:0] neg_s32(input logic signed [DataW-1:0] v);
		logic signed [DataW-1:0] r;
		if (v == MinS32) begin
			r = MaxS32;
		end else begin
			r = -v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/dpcpc_mul.sv
// shared signed multiplier with registered product
`default_nettype none
module dpcpc_mul (
	input wire logic clk,
	input wire logic signed [dpcpc_pkg::OpW-1:0] op_a,
	input wire logic signed [dpcpc_pkg::OpW-1:0] op_b,
	output logic signed [dpcpc_pkg::ProdW-1:0] prod
);
	import dpcpc_pkg::*;

	logic signed [ProdW-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= ProdW'(op_a) * ProdW'(op_b);
	end

	assign prod = prod_s1;

endmodule
`default_nettype wire

FILE: design/dual_pid_cart_pendulum_controller_unit.sv
// top level: two pid loops sharing one multiplier under a small sequencer
//
// usage:
//  - input channel in_valid/in_ready/in_data carries one control tick per request
//  - output channel out_valid/out_ready/out_data returns one drive force per tick
//  - cfg_we/cfg_index/cfg_data write the gains, travel distance and switch period;
//    writing travel distance or switch period also reloads the target or switch time
//  - a tick runs flip check, error setup, then eight products through one
//    33x33 multiplier, one per cycle, with integrals and force accumulated
//    behind it, and the result is then loaded into the output register
//  - the next request is taken only back in idle, so a new tick is never
//    taken while the last one is still in progress
//  - the result sits in an output register; a new request is taken while it
//    waits, and the sequencer holds its last step only if that register is
//    still full when the next result is ready
//  - reset loads the default gains, target and switch time and clears the
//    error histories and integrals; no output is pending after reset
`default_nettype none
module dual_pid_cart_pendulum_controller_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire dpcpc_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output dpcpc_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [dpcpc_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [dpcpc_pkg::DataW-1:0] cfg_data
);
	import dpcpc_pkg::*;

	// configuration
	logic signed [DataW-1:0] cart_kp_q, cart_ki_q, cart_kd_q;
	logic signed [DataW-1:0] pend_kp_q, pend_ki_q, pend_kd_q;
	logic [DataW-1:0] period_q;

	// controller state
	logic signed [DataW-1:0] target_q;
	logic [DataW-1:0] next_sw_q;
	logic signed [DataW-1:0] cart_prev_q, cart_int_q, pend_prev_q, pend_int_q;

	// per tick
	state_t state_q, state_d;
	logic [StepCntW-1:0] cnt_q;
	in_item_t in_q;
	logic flipped_q;
	logic signed [DataW-1:0] e_cart_q, d_pend_q;
	logic signed [SumW-1:0] acc_q;
	logic out_valid_q;
	out_item_t out_q;

	logic signed [OpW-1:0] op_a, op_b;
	logic signed [ProdW-1:0] prod;
	logic [2:0] issue_op, done_op;
	logic do_flip;
	logic [DataW:0] next_sw_sum;
	logic signed [DataW:0] cart_diff;
	logic signed [SumW-1:0] inc_ext, term_ext;
	logic load_out;

	assign issue_op = cnt_q[2:0];
	assign done_op = 3'(cnt_q - StepCntW'(1));
	assign do_flip = (in_q.sim_time >= next_sw_q);
	assign next_sw_sum = {1'b0, next_sw_q} + {1'b0, period_q};
	assign cart_diff = OpW'(in_q.cart_position) - OpW'(target_q);
	assign inc_ext = SumW'($signed(prod[ProdW-1:17]));
	assign term_ext = SumW'($signed(prod[ProdW-1:16]));

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (issue_op)
			OP_CART_TRAP: begin
				op_a = OpW'(cart_prev_q) + OpW'(e_cart_q);
				op_b = $signed({1'b0, in_q.step_len});
			end
			OP_PEND_TRAP: begin
				op_a = OpW'(pend_prev_q) + OpW'(in_q.pendulum_angle);
				op_b = $signed({1'b0, in_q.step_len});
			end
			OP_CART_KP: begin
				op_a = OpW'(cart_kp_q);
				op_b = OpW'(e_cart_q);
			end
			OP_CART_KD: begin
				op_a = OpW'(cart_kd_q);
				op_b = OpW'(in_q.cart_velocity);
			end
			OP_PEND_KP: begin
				op_a = OpW'(pend_kp_q);
				op_b = OpW'(in_q.pendulum_angle);
			end
			OP_PEND_KD: begin
				op_a = OpW'(pend_kd_q);
				op_b = OpW'(d_pend_q);
			end
			OP_CART_KI: begin
				op_a = OpW'(cart_ki_q);
				op_b = OpW'(cart_int_q);
			end
			OP_PEND_KI: begin
				op_a = OpW'(pend_ki_q);
				op_b = OpW'(pend_int_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	dpcpc_mul u_mul (
		.clk (clk),
		.op_a(op_a),
		.op_b(op_b),
		.prod(prod)
	);

	always_comb begin
		state_d = state_q;
		load_out = 1'b0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_FLIP;
				end
			end
			ST_FLIP: begin
				state_d = ST_ERR;
			end
			ST_ERR: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == StepCntW'(NumOps)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				cnt_q <= cnt_q + StepCntW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_kp_q <= RstCartKp;
			cart_ki_q <= RstCartKi;
			cart_kd_q <= RstCartKd;
			pend_kp_q <= RstPendKp;
			pend_ki_q <= RstPendKi;
			pend_kd_q <= RstPendKd;
			period_q <= RstPeriod;
			target_q <= RstTravel;
			next_sw_q <= RstPeriod;
			cart_prev_q <= '0;
			cart_int_q <= '0;
			pend_prev_q <= '0;
			pend_int_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CART_KP: cart_kp_q <= $signed(cfg_data);
					REG_CART_KI: cart_ki_q <= $signed(cfg_data);
					REG_CART_KD: cart_kd_q <= $signed(cfg_data);
					REG_PEND_KP: pend_kp_q <= $signed(cfg_data);
					REG_PEND_KI: pend_ki_q <= $signed(cfg_data);
					REG_PEND_KD: pend_kd_q <= $signed(cfg_data);
					REG_TRAVEL: target_q <= $signed(cfg_data);
					REG_PERIOD: begin
						period_q <= cfg_data;
						next_sw_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end else if (state_q == ST_FLIP && do_flip) begin
				target_q <= neg_s32(target_q);
				next_sw_q <= next_sw_sum[DataW] ? '1 : next_sw_sum[DataW-1:0];
				cart_prev_q <= '0;
				cart_int_q <= '0;
				pend_prev_q <= '0;
				pend_int_q <= '0;
			end else if (state_q == ST_MUL) begin
				if (cnt_q < StepCntW'(NumOps)) begin
					if (issue_op == OP_CART_TRAP) begin
						cart_prev_q <= e_cart_q;
					end
					if (issue_op == OP_PEND_TRAP) begin
						pend_prev_q <= in_q.pendulum_angle;
					end
				end
				if (cnt_q != '0) begin
					if (done_op == OP_CART_TRAP) begin
						cart_int_q <= sat_s32(SumW'(cart_int_q) + inc_ext);
					end
					if (done_op == OP_PEND_TRAP) begin
						pend_int_q <= sat_s32(SumW'(pend_int_q) + inc_ext);
					end
				end
			end
		end
	end

	// tick data path
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
		if (state_q == ST_FLIP) begin
			flipped_q <= do_flip;
		end
		if (state_q == ST_ERR) begin
			e_cart_q <= sat_s32(SumW'(cart_diff));
			d_pend_q <= neg_s32(in_q.pendulum_rate);
			acc_q <= '0;
		end else if (state_q == ST_MUL && cnt_q != '0 && done_op != OP_CART_TRAP
			&& done_op != OP_PEND_TRAP) begin
			acc_q <= acc_q + term_ext;
		end
		if (load_out) begin
			out_q.drive_force <= sat_s32(acc_q);
			out_q.target_flipped <= flipped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("request taken while a tick is in progress");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_FLIP))
		else $error("accepted request did not start the sequence");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q <= StepCntW'(NumOps)))
		else $error("step counter past the last product");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result appeared without finishing a tick");

endmodule
`default_nettype wire
